@@ src/cpiq_pkg.sv @@
package cpiq_pkg;

	// fixed field widths
	localparam int TIME_BITS     = 32;
	localparam int SAMPLE_BITS   = 10;
	localparam int DEBOUNCE_BITS = 16;
	localparam int LIMIT_BITS    = 10;
	localparam int CFG_BITS      = 16;
	localparam int CODE_BITS     = 4;
	localparam int SLOTS         = 5;

	// default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 2;

	// event slots, in emission order
	localparam int SLOT_UP    = 0;
	localparam int SLOT_DOWN  = 1;
	localparam int SLOT_FWD   = 2;
	localparam int SLOT_RIGHT = 3;
	localparam int SLOT_LEFT  = 4;

	typedef enum logic [1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_FORWARD  = 2'd1,
		REG_RIGHT    = 2'd2,
		REG_LEFT     = 2'd3
	} cpiq_reg_t;

	typedef enum logic [CODE_BITS-1:0] {
		EV_UP_PRESSED   = 4'd0,
		EV_UP_RELEASED  = 4'd1,
		EV_DOWN_PRESSED = 4'd2,
		EV_DOWN_RELEASED = 4'd3,
		EV_FORWARD      = 4'd4,
		EV_STOP         = 4'd5,
		EV_RIGHT        = 4'd6,
		EV_NEUTRAL      = 4'd7,
		EV_LEFT         = 4'd8
	} cpiq_code_t;

	typedef struct packed {
		logic [TIME_BITS-1:0]   now_ms;
		logic                   up_level;
		logic                   down_level;
		logic [SAMPLE_BITS-1:0] forward_sample;
		logic [SAMPLE_BITS-1:0] lateral_sample;
	} cpiq_poll_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] event_code;
		logic                 last_event;
	} cpiq_result_t;

	typedef struct packed {
		logic [DEBOUNCE_BITS-1:0] debounce_time;
		logic [LIMIT_BITS-1:0]    forward_limit;
		logic [LIMIT_BITS-1:0]    right_limit;
		logic [LIMIT_BITS-1:0]    left_limit;
	} cpiq_cfg_t;

	// events of one poll: which slots fire, and the new flag of each
	typedef struct packed {
		logic [SLOTS-1:0] mask;
		logic [SLOTS-1:0] val;
	} cpiq_evset_t;

	// event code of one slot given its new flag value
	function automatic logic [CODE_BITS-1:0] slot_code(input int slot, input logic val);
		cpiq_code_t c;
		c = EV_NEUTRAL;
		case (slot)
			SLOT_UP:    c = val ? EV_UP_PRESSED : EV_UP_RELEASED;
			SLOT_DOWN:  c = val ? EV_DOWN_PRESSED : EV_DOWN_RELEASED;
			SLOT_FWD:   c = val ? EV_FORWARD : EV_STOP;
			SLOT_RIGHT: c = val ? EV_RIGHT : EV_NEUTRAL;
			SLOT_LEFT:  c = val ? EV_LEFT : EV_NEUTRAL;
			default:    c = EV_NEUTRAL;
		endcase
		return c;
	endfunction

endpackage

@@ src/control_pad_input_qualifier.sv @@
// channel   | handshake         | payload
// ----------+-------------------+-------------------------------------------
// poll in   | push / full       | poll: now_ms, up_level, down_level, samples
// result    | empty / pop       | result: event_code, last_event
// config    | cfg_we            | cfg_index, cfg_data
//
// a poll is classified in the cycle of its transfer and a non-empty event set enters
// the queue at that same edge; its first event passes through the queue and the
// output register before it is shown, and the rest follow at one per cycle while
// results are popped; at most five events per poll leave the serial event emitter
// polls keep being taken while the queue of QUEUE_DEPTH event sets has room
// reset clears all qualifier state and loads the register defaults
module control_pad_input_qualifier import cpiq_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  cpiq_poll_t          poll,
	output logic                empty,
	input  logic                pop,
	output cpiq_result_t        result,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_index,
	input  logic [CFG_BITS-1:0] cfg_data
);

	cpiq_cfg_t   cfg_q;
	logic        q_full;
	logic        q_push;
	cpiq_evset_t q_wdata;
	logic        q_pop;
	logic        q_empty;
	cpiq_evset_t q_head;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_time <= DEBOUNCE_BITS'(50);
			cfg_q.forward_limit <= LIMIT_BITS'(256);
			cfg_q.right_limit   <= LIMIT_BITS'(256);
			cfg_q.left_limit    <= LIMIT_BITS'(768);
		end else if (cfg_we) begin
			case (cpiq_reg_t'(cfg_index))
				REG_DEBOUNCE: cfg_q.debounce_time <= cfg_data[DEBOUNCE_BITS-1:0];
				REG_FORWARD:  cfg_q.forward_limit <= cfg_data[LIMIT_BITS-1:0];
				REG_RIGHT:    cfg_q.right_limit   <= cfg_data[LIMIT_BITS-1:0];
				REG_LEFT:     cfg_q.left_limit    <= cfg_data[LIMIT_BITS-1:0];
				default: ;
			endcase
		end
	end

	cpiq_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.poll   (poll),
		.cfg    (cfg_q),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	cpiq_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.head   (q_head)
	);

	cpiq_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_head  (q_head),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.result  (result)
	);

endmodule

@@ src/cpiq_front.sv @@
module cpiq_front import cpiq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  cpiq_poll_t  poll,
	input  cpiq_cfg_t   cfg,
	input  logic        q_full,
	output logic        q_push,
	output cpiq_evset_t q_data
);

	logic                 up_pressed_q;
	logic                 down_pressed_q;
	logic [TIME_BITS-1:0] up_chg_q;
	logic [TIME_BITS-1:0] down_chg_q;
	logic                 fwd_active_q;
	logic                 right_active_q;
	logic                 left_active_q;

	logic                 accept;
	logic [TIME_BITS-1:0] now;
	logic [TIME_BITS-1:0] up_elapsed;
	logic [TIME_BITS-1:0] down_elapsed;
	logic [TIME_BITS-1:0] deb_ext;
	logic                 up_pressed_d;
	logic                 down_pressed_d;
	logic [TIME_BITS-1:0] up_chg_d;
	logic [TIME_BITS-1:0] down_chg_d;
	logic                 up_ev;
	logic                 down_ev;
	logic                 fwd_cur;
	logic                 right_cur;
	logic                 left_cur;

	localparam int CMP_BITS = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;

	assign full   = q_full;
	assign accept = push && !q_full;

	// zero time reads as one, so zero can mark no pending change
	assign now = (poll.now_ms == '0) ? TIME_BITS'(1) : poll.now_ms;

	assign up_elapsed   = now - up_chg_q;
	assign down_elapsed = now - down_chg_q;
	assign deb_ext      = TIME_BITS'(cfg.debounce_time);

	// up button debounce
	always_comb begin
		up_pressed_d = up_pressed_q;
		up_chg_d     = up_chg_q;
		up_ev        = 1'b0;
		if (up_chg_q == '0 && up_pressed_q == poll.up_level) begin
			up_chg_d = now;
		end else if (up_elapsed > deb_ext) begin
			up_chg_d = '0;
			if (up_pressed_q == poll.up_level) begin
				up_pressed_d = !poll.up_level;
				up_ev        = 1'b1;
			end
		end
	end

	// down button debounce
	always_comb begin
		down_pressed_d = down_pressed_q;
		down_chg_d     = down_chg_q;
		down_ev        = 1'b0;
		if (down_chg_q == '0 && down_pressed_q == poll.down_level) begin
			down_chg_d = now;
		end else if (down_elapsed > deb_ext) begin
			down_chg_d = '0;
			if (down_pressed_q == poll.down_level) begin
				down_pressed_d = !poll.down_level;
				down_ev        = 1'b1;
			end
		end
	end

	// joystick thresholds
	assign fwd_cur   = CMP_BITS'(poll.forward_sample) < CMP_BITS'(cfg.forward_limit);
	assign right_cur = CMP_BITS'(poll.lateral_sample) < CMP_BITS'(cfg.right_limit);
	assign left_cur  = CMP_BITS'(poll.lateral_sample) > CMP_BITS'(cfg.left_limit);

	// event set of this poll
	always_comb begin
		q_data.mask[SLOT_UP]    = up_ev;
		q_data.mask[SLOT_DOWN]  = down_ev;
		q_data.mask[SLOT_FWD]   = fwd_cur != fwd_active_q;
		q_data.mask[SLOT_RIGHT] = right_cur != right_active_q;
		q_data.mask[SLOT_LEFT]  = left_cur != left_active_q;
		q_data.val[SLOT_UP]     = up_pressed_d;
		q_data.val[SLOT_DOWN]   = down_pressed_d;
		q_data.val[SLOT_FWD]    = fwd_cur;
		q_data.val[SLOT_RIGHT]  = right_cur;
		q_data.val[SLOT_LEFT]   = left_cur;
	end

	assign q_push = accept && (q_data.mask != '0);

	// qualifier state, updated on each transfer in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_pressed_q   <= 1'b0;
			down_pressed_q <= 1'b0;
			up_chg_q       <= '0;
			down_chg_q     <= '0;
			fwd_active_q   <= 1'b0;
			right_active_q <= 1'b0;
			left_active_q  <= 1'b0;
		end else if (accept) begin
			up_pressed_q   <= up_pressed_d;
			down_pressed_q <= down_pressed_d;
			up_chg_q       <= up_chg_d;
			down_chg_q     <= down_chg_d;
			fwd_active_q   <= fwd_cur;
			right_active_q <= right_cur;
			left_active_q  <= left_cur;
		end
	end

endmodule

@@ src/cpiq_fifo.sv @@
module cpiq_fifo import cpiq_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  cpiq_evset_t wdata,
	output logic        full,
	input  logic        pop,
	output logic        empty,
	output cpiq_evset_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cpiq_evset_t      mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = count_q == CNT_W'(DEPTH);
	assign empty   = count_q == '0;
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ src/cpiq_back.sv @@
module cpiq_back import cpiq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         q_empty,
	input  cpiq_evset_t  q_head,
	output logic         q_pop,
	input  logic         pop,
	output logic         empty,
	output cpiq_result_t result
);

	logic [SLOTS-1:0] done_q;
	logic             out_valid_q;
	cpiq_result_t     out_q;

	logic [SLOTS-1:0] pend;
	logic [SLOTS-1:0] sel;
	logic [SLOTS-1:0] rest;
	logic             adv;
	logic             emit;
	logic             last;
	logic [CODE_BITS-1:0] code;

	// lowest pending slot of the head entry
	assign pend = q_head.mask & ~done_q;
	assign sel  = pend & (~pend + SLOTS'(1));
	assign rest = pend & ~sel;
	assign last = rest == '0;

	always_comb begin
		code = '0;
		for (int i = 0; i < SLOTS; i++) begin
			if (sel[i]) begin
				code = slot_code(i, q_head.val[i]);
			end
		end
	end

	assign adv   = !out_valid_q || pop;
	assign emit  = adv && !q_empty;
	assign q_pop = emit && last;

	// progress through the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= '0;
		end else if (emit) begin
			done_q <= last ? '0 : (done_q | sel);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= !q_empty;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.event_code <= code;
			out_q.last_event <= last;
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

@@ src/cpiq_checker.sv @@
module cpiq_checker import cpiq_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	input logic         pop,
	input logic         empty,
	input cpiq_result_t result
);

	// nothing to show while in reset
	a_reset_empty: assert property (@(posedge clk) !arst_n |-> empty)
		else $error("result shown during reset");

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(result))
		else $error("stalled result changed");

	// codes stay within the defined set
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> result.event_code <= EV_LEFT)
		else $error("undefined event code");

	// events of one poll follow without a gap
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !result.last_event |=> !empty)
		else $error("gap inside one poll's events");

	// events of one poll leave in slot order
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !empty && !result.last_event |=>
		result.event_code >= $past(result.event_code))
		else $error("events out of order");

endmodule

bind control_pad_input_qualifier cpiq_checker u_cpiq_checker (.*);
